[hw/rtl/msb_pkg.sv]
// Shared types and constants for the multi-stack shared buffer.
package msb_pkg;

    localparam int DATA_W = 32;
    localparam int SID_W  = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic commit;
    } t_dp_cmd;

endpackage

[hw/rtl/msb_req_if.sv]
// Request channel: operation, stack number and value to push.
interface msb_req_if import msb_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SID_W-1:0]         stack_index;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output mode, output stack_index, output push_value,
                    input ready);
    modport sink   (input valid, input mode, input stack_index, input push_value,
                    output ready);

endinterface

[hw/rtl/msb_rsp_if.sv]
// Response channel: completion status and popped value.
interface msb_rsp_if import msb_pkg::*; ();

    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [DATA_W-1:0] popped_value;

    modport source (output valid, output status, output popped_value, input ready);
    modport sink   (input valid, input status, input popped_value, output ready);

endinterface

[hw/rtl/msb_ctrl.sv]
// Sequencing state machine for the multi-stack shared buffer.
module msb_ctrl import msb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   w_capture;
    logic   w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_capture   = i_in_valid && o_in_ready;
    // The result may only be written once the previous one has left.
    assign w_commit    = (r_state == S_COMMIT) && (!r_out_vld || i_out_ready);
    assign o_out_valid = r_out_vld;

    assign o_cmd.capture = w_capture;
    assign o_cmd.fetch   = (r_state == S_READ);
    assign o_cmd.commit  = w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_capture) r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_commit) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/msb_dp.sv]
// Datapath: slot data, link and top-pointer stores with the free list head.
module msb_dp import msb_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic                     i_mode,
    input  logic [SID_W-1:0]         i_stack_index,
    input  logic signed [DATA_W-1:0] i_push_value,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_popped_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);

    logic [DATA_W-1:0] r_data_mem [CAPACITY];
    logic [LW-1:0]     r_link_mem [CAPACITY];
    logic [LW-1:0]     r_top_mem  [NUM_STACKS];
    logic [NUM_STACKS-1:0] r_top_vld;

    logic              r_mode;
    logic              r_sid_ok;
    logic [SW-1:0]     r_sidx;
    logic [DATA_W-1:0] r_val;
    logic [LW-1:0]     r_free_head;
    logic [LW-1:0]     r_fill;
    logic [LW-1:0]     r_top_q;
    logic              r_top_v;
    logic [LW-1:0]     r_flink_q;
    logic [LW-1:0]     r_tlink_q;
    logic [DATA_W-1:0] r_tdata_q;
    t_status           r_status;
    logic [DATA_W-1:0] r_popped;

    logic [SW+1:0]     w_sid_ext;
    logic [SW-1:0]     w_sidx;
    logic              w_sid_ok;
    logic [LW-1:0]     w_top;
    logic [LW-1:0]     w_flink;
    logic [AW-1:0]     w_lrd_addr;
    logic              w_push_ok;
    logic              w_pop_ok;

    assign w_sid_ext = (SW + 2)'(i_stack_index);
    assign w_sidx    = w_sid_ext[SW-1:0];
    assign w_sid_ok  = (int'(i_stack_index) < NUM_STACKS);

    assign w_top = r_top_v ? r_top_q : LINK_NULL;
    // Slots at or above the fill mark were never written and still chain in order.
    assign w_flink = (r_free_head < r_fill) ? r_flink_q : (r_free_head + LW'(1));
    assign w_lrd_addr = i_cmd.fetch ? w_top[AW-1:0] : r_free_head[AW-1:0];

    assign w_push_ok = (r_mode == MODE_PUSH) && r_sid_ok && (r_free_head < LINK_NULL);
    assign w_pop_ok  = (r_mode == MODE_POP) && r_sid_ok && (w_top < LINK_NULL);

    assign o_status       = r_status;
    assign o_popped_value = r_popped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fill      <= '0;
            r_top_vld   <= '0;
        end else if (i_cmd.commit) begin
            if (w_push_ok) begin
                r_free_head       <= w_flink;
                r_top_vld[r_sidx] <= 1'b1;
                if (r_free_head == r_fill) r_fill <= r_fill + LW'(1);
            end else if (w_pop_ok) begin
                r_free_head <= w_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_sid_ok  <= w_sid_ok;
            r_sidx    <= w_sidx;
            r_val     <= i_push_value;
            r_top_q   <= r_top_mem[w_sidx];
            r_top_v   <= r_top_vld[w_sidx];
            r_flink_q <= r_link_mem[w_lrd_addr];
        end
        if (i_cmd.fetch) begin
            r_tlink_q <= r_link_mem[w_lrd_addr];
            r_tdata_q <= r_data_mem[w_top[AW-1:0]];
        end
        if (i_cmd.commit) begin
            if (w_push_ok) begin
                r_data_mem[r_free_head[AW-1:0]] <= r_val;
                r_link_mem[r_free_head[AW-1:0]] <= w_top;
                r_top_mem[r_sidx]               <= r_free_head;
            end else if (w_pop_ok) begin
                r_link_mem[w_top[AW-1:0]] <= r_free_head;
                r_top_mem[r_sidx]         <= r_tlink_q;
            end
            if (r_mode == MODE_PUSH) begin
                r_status <= w_push_ok ? ST_DONE : ST_FULL;
                r_popped <= '0;
            end else begin
                r_status <= w_pop_ok ? ST_DONE : ST_EMPTY;
                r_popped <= w_pop_ok ? r_tdata_q : '0;
            end
        end
    end

endmodule

[hw/rtl/multi_stack_shared_buffer_core.sv]
// Several LIFO stacks sharing one slot store, linked through a free list.
// Each transaction runs as capture and top/free-link read, then the
// popped slot's link and data read, then the store update and result write.
// The response register is written by the commit step, which waits until the
// previous response has been taken; a new request is accepted only when idle.
// Synchronous active-low reset empties every stack and restores the free list.
module multi_stack_shared_buffer_core import msb_pkg::*; #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msb_req_if.sink    i_req,
    msb_rsp_if.source  o_rsp
);

    t_dp_cmd w_cmd;

    msb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    msb_dp #(
        .NUM_STACKS (NUM_STACKS),
        .CAPACITY   (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (i_req.mode),
        .i_stack_index  (i_req.stack_index),
        .i_push_value   (i_req.push_value),
        .o_status       (o_rsp.status),
        .o_popped_value (o_rsp.popped_value)
    );

endmodule
